@@ sv/kbsc_pkg.sv @@
`default_nettype none

package kbsc_pkg;

    // Field and register widths.
    localparam int DATA_W      = 8;
    localparam int KEY_LEN_W   = 6;
    localparam int KEY_WORD_W  = 64;
    localparam int KEY_WORDS   = 4;
    localparam int KEY_BYTES   = KEY_WORDS * KEY_WORD_W / 8;
    localparam int KEY_IDX_W   = 5;
    localparam int CNT_W       = 16;
    localparam int AMT_W       = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_KEY_BYTES_DEF = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_SECOND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_THIRD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH    = 3'd4;

    // Counter constants.
    localparam logic [CNT_W-1:0] MIX_INIT  = 16'hAAAA;
    localparam logic [CNT_W-1:0] ROT_INIT  = 16'h0000;
    localparam logic [CNT_W-1:0] LOW_MASK  = 16'h00FF;
    localparam logic [CNT_W-1:0] ROT_STEP  = 16'd16;
    localparam logic [AMT_W-1:0] AMT_LAST  = 5'd1;
    localparam logic [AMT_W-1:0] AMT_DEC   = 5'd2;

    // Controller state, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_ROUND = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic setup;
        logic round;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic key_short;
        logic last_round;
        logic out_free;
    } stat_t;

    // Rotate right of a 16-bit word by 0 to 15 bits.
    function automatic logic [CNT_W-1:0] ror16(input logic [CNT_W-1:0] v,
                                               input logic [3:0] s);
        logic [2*CNT_W-1:0] tmp;
        begin
            tmp = {v, v} >> s;
            return tmp[CNT_W-1:0];
        end
    endfunction

    // One scrambling round of the mix counter.
    function automatic logic [CNT_W-1:0] mix_round(input logic [CNT_W-1:0] t,
                                                   input logic [AMT_W-1:0] amt);
        logic [CNT_W-1:0] a;
        begin
            a = ror16(t, amt[3:0]);
            a = {a[7:0], a[15:8]};
            a = a ^ LOW_MASK;
            a = {a[14:0], a[15]};
            a = a ^ MIX_INIT;
            a = {a[15:8], a[6:0], a[7]};
            return a;
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/kbsc_ctrl.sv @@
`default_nettype none

// Sequencer: accept, setup, scrambling rounds, output hand-off.
module kbsc_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire kbsc_pkg::stat_t stat,
    output kbsc_pkg::cmd_t       cmd
);

    kbsc_pkg::state_t state_reg;
    kbsc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kbsc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.setup   = 1'b0;
        cmd.round   = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            kbsc_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                // A request with a short key is taken and dropped.
                if (s_tvalid && !stat.key_short)
                begin
                    state_next = kbsc_pkg::ST_SETUP;
                end
            end
            kbsc_pkg::ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = kbsc_pkg::ST_ROUND;
            end
            kbsc_pkg::ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (stat.last_round)
                begin
                    state_next = kbsc_pkg::ST_OUT;
                end
            end
            kbsc_pkg::ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = kbsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kbsc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/kbsc_dp.sv @@
`default_nettype none

// Key registers, counters, rotator and output register.
module kbsc_dp
#(
    parameter int MAX_KEY_BYTES = kbsc_pkg::MAX_KEY_BYTES_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [kbsc_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [kbsc_pkg::KEY_WORD_W-1:0] wr_data,
    input  wire logic [kbsc_pkg::DATA_W-1:0]    s_tdata,
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [kbsc_pkg::DATA_W-1:0]         m_tdata,
    input  wire kbsc_pkg::cmd_t                 cmd,
    output kbsc_pkg::stat_t                     stat
);

    localparam int KP_W = (MAX_KEY_BYTES > 2) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [kbsc_pkg::KEY_LEN_W-1:0] MAX_LEN =
        kbsc_pkg::KEY_LEN_W'(MAX_KEY_BYTES);

    logic [kbsc_pkg::KEY_LEN_W-1:0]  key_length_reg;
    logic [kbsc_pkg::KEY_WORD_W-1:0] key_words_reg [kbsc_pkg::KEY_WORDS];
    logic [kbsc_pkg::CNT_W-1:0]      mix_reg;
    logic [kbsc_pkg::CNT_W-1:0]      rot_reg;
    logic [KP_W-1:0]                 pos_reg;
    logic [kbsc_pkg::DATA_W-1:0]     data_reg;
    logic                            start_reg;
    logic [kbsc_pkg::DATA_W-1:0]     b_reg;
    logic [kbsc_pkg::CNT_W-1:0]      t1_reg;
    logic [kbsc_pkg::AMT_W-1:0]      amt_reg;
    logic                            out_valid_reg;
    logic [kbsc_pkg::DATA_W-1:0]     out_reg;

    logic [kbsc_pkg::KEY_BYTES*8-1:0] key_flat;
    logic [kbsc_pkg::KEY_LEN_W-1:0]   len_eff;
    logic [kbsc_pkg::CNT_W-1:0]       mix_cur;
    logic [kbsc_pkg::CNT_W-1:0]       rot_cur;
    logic [KP_W-1:0]                  pos_cur;
    logic [KP_W-1:0]                  pos_use;
    logic [KP_W-1:0]                  pos_next;
    logic [kbsc_pkg::KEY_LEN_W-1:0]   pos_inc;
    logic [kbsc_pkg::KEY_IDX_W-1:0]   key_idx;
    logic [kbsc_pkg::DATA_W-1:0]      key_byte;
    logic [kbsc_pkg::CNT_W-1:0]       t2_a;
    logic [kbsc_pkg::CNT_W-1:0]       t2_b;
    logic [kbsc_pkg::CNT_W-1:0]       t2_new;
    logic                             out_free;

    assign key_flat = {key_words_reg[3], key_words_reg[2],
                       key_words_reg[1], key_words_reg[0]};
    assign len_eff  = (key_length_reg > MAX_LEN) ? MAX_LEN : key_length_reg;

    // Counters as they stand for this byte, after an optional restart.
    assign mix_cur = start_reg ? kbsc_pkg::MIX_INIT : mix_reg;
    assign rot_cur = start_reg ? ({key_flat[15:8], key_flat[7:0]}
                                  ^ kbsc_pkg::CNT_W'(len_eff))
                               : rot_reg;
    assign pos_cur = start_reg ? '0 : pos_reg;
    assign pos_use = (kbsc_pkg::KEY_LEN_W'(pos_cur) >= len_eff) ? '0 : pos_cur;
    assign pos_inc = kbsc_pkg::KEY_LEN_W'(pos_use) + 1'b1;
    assign pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[KP_W-1:0];

    assign key_idx  = kbsc_pkg::KEY_IDX_W'(pos_use);
    assign key_byte = key_flat[key_idx*8 +: 8];

    // Rotate counter update: fold the high byte into the low one, rotate by
    // its own low nibble, mix in the old mix counter and step.
    assign t2_a   = {rot_cur[15:8], rot_cur[7:0] ^ rot_cur[15:8]};
    assign t2_b   = kbsc_pkg::ror16(t2_a, t2_a[3:0]);
    assign t2_new = (t2_b ^ mix_cur) + kbsc_pkg::ROT_STEP;

    assign out_free = !out_valid_reg || m_tready;

    assign stat.key_short  = (len_eff < kbsc_pkg::KEY_LEN_W'(2));
    assign stat.last_round = (amt_reg == kbsc_pkg::AMT_LAST);
    assign stat.out_free   = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg   <= '0;
            key_words_reg[0] <= '0;
            key_words_reg[1] <= '0;
            key_words_reg[2] <= '0;
            key_words_reg[3] <= '0;
            mix_reg          <= kbsc_pkg::MIX_INIT;
            rot_reg          <= kbsc_pkg::ROT_INIT;
            pos_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    kbsc_pkg::REG_KEY_LENGTH:
                        key_length_reg <= wr_data[kbsc_pkg::KEY_LEN_W-1:0];
                    kbsc_pkg::REG_KEY_LOW:    key_words_reg[0] <= wr_data;
                    kbsc_pkg::REG_KEY_SECOND: key_words_reg[1] <= wr_data;
                    kbsc_pkg::REG_KEY_THIRD:  key_words_reg[2] <= wr_data;
                    kbsc_pkg::REG_KEY_HIGH:   key_words_reg[3] <= wr_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.setup)
            begin
                rot_reg <= t2_new;
                pos_reg <= pos_next;
            end
            if (cmd.commit)
            begin
                mix_reg <= t1_reg;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            data_reg  <= s_tdata;
            start_reg <= s_tuser;
        end
        if (cmd.setup)
        begin
            b_reg   <= data_reg ^ key_byte;
            t1_reg  <= mix_cur;
            amt_reg <= {t2_new[4:1], 1'b1};
        end
        if (cmd.round)
        begin
            t1_reg  <= kbsc_pkg::mix_round(t1_reg, amt_reg);
            amt_reg <= amt_reg - kbsc_pkg::AMT_DEC;
        end
        if (cmd.commit)
        begin
            out_reg <= b_reg ^ t1_reg[7:0];
        end
    end

endmodule

`default_nettype wire

@@ sv/keyed_byte_stream_cipher.sv @@
// Each byte that is not dropped draws 1 to 16 scrambling rounds, run by the
// single shared round unit at one scrambling round per cycle. A new request
// is taken only after the previous byte has gone into the output register.
// Reset (rst_n, asynchronous, active low) clears the key, the key length,
// the key position and the output, and sets the counters to 0xAAAA and 0.
`default_nettype none

// Keyed byte stream cipher.
//
// The controller walks each byte through four steps. In the accept cycle the
// byte and its message start flag are captured. A request that arrives while
// the effective key length is below two is taken and dropped; no counter moves.
// In the setup cycle the counters are restarted if the byte opens a
// message, the key byte is XORed in, the key position advances, and the rotate
// counter is updated; its new value sets the number of scrambling rounds and
// the first rotate amount. Each following cycle runs one scrambling round on
// the mix counter through a 16-bit barrel rotator. In the last step the result
// is written into the output register once it is free, so a new request can be
// taken while a finished result still waits for the downstream side.
module keyed_byte_stream_cipher
#(
    parameter int MAX_KEY_BYTES = kbsc_pkg::MAX_KEY_BYTES_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration write port.
    input  wire logic                            wr_en,
    input  wire logic [kbsc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [kbsc_pkg::KEY_WORD_W-1:0] wr_data,
    // Input stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [kbsc_pkg::DATA_W-1:0]     s_tdata,  // [7:0] data_byte
    input  wire logic                            s_tuser,  // [0] message_start
    // Output stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [kbsc_pkg::DATA_W-1:0]          m_tdata   // [7:0] out_byte
);

    kbsc_pkg::cmd_t  cmd;
    kbsc_pkg::stat_t stat;

    kbsc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kbsc_dp
    #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none

// Self-checking bench for the keyed byte stream cipher.
//
// The bench keeps its own copy of the cipher state, the mix counter, the
// rotate counter and the key position, together with the key registers. It
// updates that copy for every request the block accepts. When the copy says a
// byte must come out, the predicted byte is queued. Every result the block
// hands over is compared with the oldest queued byte.
//
// The run has two parts. The first is a short list of requests and register
// writes covering the corner cases: the key left at length zero after reset,
// a one-byte key, bytes sent before any message start, a key length above
// the key size, and a key length lowered in mid-message. The second part
// runs random phases. Each phase loads a new key length and often a new key,
// then sends random messages with both sides idling in one of four patterns.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kbsc_pkg::*;

    localparam int KEY_CAP       = MAX_KEY_BYTES_DEF;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = 40;     // longer than one full byte of work
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DIRECTED_ROWS = 31;

    // Register indexes past the end of the list; writes there are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_KEY_HIGH + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;
    typedef enum logic {RES_PREDICT, RES_NONE} row_result_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [63:0]          val;
        logic [7:0]           data;
        logic                 start;
        row_result_t          want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [KEY_WORD_W-1:0] wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata = '0;   // [7:0] data_byte
    logic                  s_tuser = 1'b0; // [0] message_start
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;        // [7:0] out_byte

    keyed_byte_stream_cipher u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Bench copy of the key registers and the cipher state.
    logic [KEY_LEN_W-1:0]  key_len_q;
    logic [KEY_WORD_W-1:0] key_word_q [KEY_WORDS];
    logic [CNT_W-1:0]      mix_q;
    logic [CNT_W-1:0]      rot_q;
    int                    kpos_q;

    // Output bytes predicted but not yet seen on the output side.
    logic [7:0] cipher_out_due [$];
    logic [7:0] due_byte;

    int errors = 0;
    int cycles = 0;

    // Idle and stall rates in percent, and the long receiver hold-off.
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_req  = 0;
    int hold_left = 0;

    function automatic void note_error(input string what, input logic [7:0] exp_v,
                                       input logic [7:0] got_v);
        errors++;
        if (errors <= 10)
            $display("%0t: %s: expected %02h, got %02h", $realtime, what, exp_v, got_v);
    endfunction

    function automatic logic [7:0] key_at(input int i);
        return key_word_q[(i >> 3) & 3][(i & 7) * 8 +: 8];
    endfunction

    function automatic logic [15:0] rotr16(input logic [15:0] v, input logic [3:0] s);
        if (s == 4'd0)
            return v;
        return (v >> s) | (v << (5'd16 - s));
    endfunction

    function automatic void key_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [63:0] val);
        case (idx)
            REG_KEY_LENGTH: key_len_q = val[KEY_LEN_W-1:0];
            REG_KEY_LOW, REG_KEY_SECOND, REG_KEY_THIRD, REG_KEY_HIGH:
                key_word_q[idx - REG_KEY_LOW] = val;
            default: ;
        endcase
    endfunction

    // Advances the bench state by one byte. Returns 1 and the output byte
    // when the block must produce a result for it.
    function automatic bit cipher_advance(input logic [7:0] data, input bit start,
                                          output logic [7:0] ob);
        int         len;
        int         rounds;
        int         amount;
        logic [15:0] t1;
        logic [15:0] t2;
        logic [7:0]  b;
        logic [7:0]  lo;
        logic [7:0]  hi;
        ob = '0;
        len = (int'(key_len_q) > KEY_CAP) ? KEY_CAP : int'(key_len_q);
        // A key shorter than two bytes turns the block off; state is kept.
        if (len < 2)
            return 1'b0;
        if (start)
        begin
            mix_q  = MIX_INIT;
            rot_q  = {key_at(1), key_at(0)} ^ 16'(len);
            kpos_q = 0;
        end
        // The key may have been shortened since the last byte.
        if (kpos_q >= len)
            kpos_q = 0;
        b = data ^ key_at(kpos_q);
        kpos_q = (kpos_q + 1 >= len) ? 0 : kpos_q + 1;

        t1 = mix_q;
        lo = rot_q[7:0];
        hi = rot_q[15:8];
        t2 = {hi, lo ^ hi};
        t2 = rotr16(t2, t2[3:0]);
        t2 = (t2 ^ t1) + ROT_STEP;
        rot_q = t2;

        rounds = int'(t2[4:1]) + 1;
        amount = 2 * int'(t2[4:1]) + 1;
        for (int r = 0; r < rounds; r++)
        begin
            t1 = rotr16(t1, 4'(amount));
            amount -= 2;
            t1 = {t1[7:0], t1[15:8]};
            t1 = t1 ^ LOW_MASK;
            t1 = {t1[14:0], t1[15]};
            t1 = t1 ^ MIX_INIT;
            t1[7:0] = {t1[6:0], t1[7]};
        end
        mix_q = t1;
        ob = b ^ t1[7:0];
        return 1'b1;
    endfunction

    // One register write; the caller lowers wr_en afterwards.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        key_reg_write(idx, val);
    endtask

    // Offers one request and waits for the handshake. The sender may idle
    // first, at the rate of the current phase.
    task automatic send_item(input logic [7:0] data, input bit start, output bit has);
        logic [7:0] ob;
        wr_en <= 1'b0;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= data;
        s_tuser  <= start;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        has = cipher_advance(data, start, ob);
        if (has)
            cipher_out_due.push_back(ob);
    endtask

    // Holds the input side quiet until every predicted byte has come out.
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        wr_en    <= 1'b0;
        do
            @(posedge clk);
        while (cipher_out_due.size() != 0);
    endtask

    // Before a register write: wait for every predicted byte to come out, then
    // give the block a full byte time more.
    task automatic drain();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] key_pick();
        case ($urandom_range(3))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Output side: compare each result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cipher_out_due.size() == 0)
                note_error("result with nothing pending", 8'h00, m_tdata);
            else
            begin
                due_byte = cipher_out_due.pop_front();
                if (m_tdata !== due_byte)
                    note_error("out_byte mismatch", due_byte, m_tdata);
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is asked for.
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Directed part. Only requests that must be dropped carry a typed
    // expectation; all others go through the bench copy of the cipher.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // Key length is zero after reset: requests are dropped.
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'h00, 1'b0, RES_NONE},
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'hFF, 1'b1, RES_NONE},
        // A one-byte key is still too short, even with a message start.
        '{ROW_WRITE, REG_KEY_LENGTH, 64'd1, 8'h00, 1'b0, RES_PREDICT},
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'h5A, 1'b1, RES_NONE},
        '{ROW_WRITE, REG_KEY_LOW, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, RES_PREDICT},
        // Writes past the register list must change nothing.
        '{ROW_WRITE, REG_SPARE_FIRST, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, RES_PREDICT},
        '{ROW_WRITE, REG_SPARE_LAST, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, RES_PREDICT},
        '{ROW_WRITE, REG_KEY_LENGTH, 64'd2, 8'h00, 1'b0, RES_PREDICT},
        // Bytes before any message start run on the reset counters.
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'h00, 1'b0, RES_PREDICT},
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'hFF, 1'b0, RES_PREDICT},
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'h80, 1'b1, RES_PREDICT},
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'h01, 1'b0, RES_PREDICT},
        '{ROW_WRITE, REG_KEY_SECOND, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, RES_PREDICT},
        '{ROW_WRITE, REG_KEY_THIRD, 64'h0, 8'h00, 1'b0, RES_PREDICT},
        '{ROW_WRITE, REG_KEY_HIGH, 64'h8000_0000_0000_0001, 8'h00, 1'b0, RES_PREDICT},
        // Largest key length; the block must clamp it to the key size.
        '{ROW_WRITE, REG_KEY_LENGTH, 64'd63, 8'h00, 1'b0, RES_PREDICT},
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'h7F, 1'b1, RES_PREDICT},
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'h55, 1'b0, RES_PREDICT},
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'hAA, 1'b0, RES_PREDICT},
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'hFE, 1'b0, RES_PREDICT},
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'h33, 1'b0, RES_PREDICT},
        // Key shortened in mid-message, below the current key position.
        '{ROW_WRITE, REG_KEY_LENGTH, 64'd3, 8'h00, 1'b0, RES_PREDICT},
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'hC3, 1'b0, RES_PREDICT},
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'h3C, 1'b0, RES_PREDICT},
        '{ROW_WRITE, REG_KEY_LENGTH, 64'd32, 8'h00, 1'b0, RES_PREDICT},
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'h00, 1'b1, RES_PREDICT},
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'hFF, 1'b1, RES_PREDICT},
        // A dropped byte must leave the message state as it was.
        '{ROW_WRITE, REG_KEY_LENGTH, 64'd1, 8'h00, 1'b0, RES_PREDICT},
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'h99, 1'b1, RES_NONE},
        '{ROW_WRITE, REG_KEY_LENGTH, 64'd32, 8'h00, 1'b0, RES_PREDICT},
        '{ROW_BYTE,  REG_KEY_LENGTH, 64'h0, 8'h66, 1'b0, RES_PREDICT}
    };

    // Key lengths for the first random phases: both ends of the range.
    int extreme_len [6] = '{2, 32, 0, 63, 1, 33};

    initial
    begin
        stim_row_t row;
        bit        has;
        bit        start;
        int        done_items;
        int        new_len;
        int        count;

        key_len_q = '0;
        for (int w = 0; w < KEY_WORDS; w++)
            key_word_q[w] = '0;
        mix_q  = MIX_INIT;
        rot_q  = ROT_INIT;
        kpos_q = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                if (i == 0 || directed_rows[i-1].kind != ROW_WRITE)
                    drain();
                cfg_write(row.idx, row.val);
            end
            else
            begin
                send_item(row.data, row.start, has);
                if (row.want == RES_NONE && has)
                    note_error("short key should drop the byte", 8'h00, row.data);
            end
        end

        // Random phases. Phase number modulo four picks the idling pattern:
        // none, sender only, receiver only, both sides.
        done_items = 0;
        for (int phase = 0; done_items < RANDOM_ITEMS; phase++)
        begin
            drain();
            case (phase % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 46;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 46;
                end
                default:
                begin
                    idle_pct  = 19;
                    stall_pct = 19;
                end
            endcase

            if (phase < 6)
                new_len = extreme_len[phase];
            else
                case ($urandom_range(9))
                    0: new_len = $urandom_range(1);
                    1: new_len = $urandom_range(63, KEY_CAP + 1);
                    default: new_len = $urandom_range(KEY_CAP, 2);
                endcase

            // Leaving the key bytes alone now and then lets a shorter key
            // length catch the key position beyond its end.
            if (phase == 0 || $urandom_range(9) < 6)
                for (int w = 0; w < KEY_WORDS; w++)
                    cfg_write(3'(REG_KEY_LOW + w), key_pick());
            if ($urandom_range(7) == 0)
                cfg_write(3'(REG_SPARE_FIRST + $urandom_range(2)), {$urandom, $urandom});
            cfg_write(REG_KEY_LENGTH, 64'(new_len));

            count = (new_len < 2) ? 6 : 30 + $urandom_range(30);
            for (int n = 0; n < count; n++)
            begin
                // Long receiver hold-off while the sender keeps offering,
                // so the output register fills and the input side stalls.
                if (phase == 1 && n == 3)
                    hold_req = 300;
                // Sender pause until everything predicted has come out.
                if (phase == 5 && n == 20)
                    wait_results_done();
                start = (n == 0) ? bit'($urandom_range(1)) : ($urandom_range(11) == 0);
                send_item(8'($urandom_range(255)), start, has);
                if (has)
                    done_items++;
            end
        end

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
